### design/backtrackable_bitset_domain_macros.svh
// Assertion macros shared by the checker of the bitset domain store.
// Depends on nothing; the asserting file supplies clock and reset.
`ifndef BACKTRACKABLE_BITSET_DOMAIN_MACROS_SVH
`define BACKTRACKABLE_BITSET_DOMAIN_MACROS_SVH
// Same-cycle implication, ignored while reset is high.
`define BBD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bbd assertion failed");
// Next-cycle implication, ignored while reset is high.
`define BBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bbd assertion failed");
// Next-cycle implication that is checked during reset too.
`define BBD_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bbd assertion failed");
`endif

### design/bbd_pkg.sv
// Package of the bitset domain store: beat types, operation codes, states.
// Depends on nothing.
package bbd_pkg;
   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] value_index;
      logic [6:0] search_level;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] result_index;
      logic [8:0] current_size;
   } rsp_type;

   localparam logic [3:0] KIND_REMOVE  = 4'd0;
   localparam logic [3:0] KIND_REDUCE  = 4'd1;
   localparam logic [3:0] KIND_ADD     = 4'd2;
   localparam logic [3:0] KIND_RESTORE = 4'd3;
   localparam logic [3:0] KIND_NEXT    = 4'd4;
   localparam logic [3:0] KIND_PREV    = 4'd5;
   localparam logic [3:0] KIND_HAVE    = 4'd6;
   localparam logic [3:0] KIND_HEAD    = 4'd7;
   localparam logic [3:0] KIND_TAIL    = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_CHK,
      ST_SWEEP,
      ST_DONE
   } state_type;
endpackage

### design/bbd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module bbd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 260
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### design/backtrackable_bitset_domain.sv
// Top level of the backtrackable bitset domain store.
// Depends on bbd_pkg and bbd_ram.
// Usage: req_* carries one operation beat (remove, reduce, add, restore or a
// query), rsp_* returns exactly one result beat per operation, and csr_*
// writes domain_size. A csr beat is always taken; it reloads every level to
// full, empties the stack and sets the size count. Write it only when idle.
// Operations run one at a time. Add and the queries go straight to the word
// sweep through the bitmap RAM, one word per cycle, NW being the number of
// bitmap words (4 by default). Remove, reduce and restore first pop the level
// stack, reading the tag of each level they check, and then sweep; an unknown
// kind answers without a sweep. A new operation is taken only in idle, which
// the block enters once the previous result is loaded into the output register.
// Reset loads domain_size = min(MAX_DOMAIN, 256) and empties the stack. The
// RAM contents are not cleared: a valid bit per level marks levels that have
// been written, and an unwritten level reads as the full domain, so there is
// no clearing pass. If the receiver stalls, the result is held in the output
// register; the next operation may still be taken and swept, but it waits in
// its final state until that register drains.
module backtrackable_bitset_domain #(
   parameter int MAX_DOMAIN = 256,
   parameter int WORD_BITS  = 64,
   parameter int MAX_LEVEL  = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  bbd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output bbd_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [8:0]      csr_data
);
   localparam int NW      = (MAX_DOMAIN + WORD_BITS - 1) / WORD_BITS;
   localparam int NLEVELS = MAX_LEVEL + 1;
   localparam int LW      = $clog2(NLEVELS);
   localparam int DEPTH   = NLEVELS * NW;
   localparam int AW      = $clog2(DEPTH);
   localparam int WC      = $clog2(NW + 1);
   localparam int CW      = $clog2(NW * WORD_BITS + 1);
   localparam logic [8:0] DS_MAX = (MAX_DOMAIN < 511) ? 9'(MAX_DOMAIN) : 9'd511;
   localparam logic [8:0] DS_RST = (MAX_DOMAIN < 256) ? 9'(MAX_DOMAIN) : 9'd256;

   bbd_pkg::state_type state_ff, state_in;
   bbd_pkg::req_type   req_ff;
   bbd_pkg::rsp_type   rsp_ff;
   logic               rsp_valid_ff;
   logic [LW-1:0]      top_ff, p_ff, src_ff, dst_ff;
   logic [8:0]         dsize_ff, size_ff;
   logic [WC-1:0]      rcnt_ff, pw_ff;
   logic               rd_vld_ff;
   logic               found_ff;
   logic [7:0]         res_ff;
   logic [CW-1:0]      cnt_ff;
   logic [NLEVELS-1:0] wvalid_ff, tvalid_ff;

   logic               accept, done_fire;
   logic [LW-1:0]      tag_cur;
   logic               pop_more, push;
   logic               w_rd_en, w_wr_en, t_rd_en, t_wr_en;
   logic [AW-1:0]      w_rd_addr, w_wr_addr;
   logic [LW-1:0]      t_rd_addr;
   logic [WORD_BITS-1:0] w_rdata, w_wdata, word_d, hits, bmask;
   logic [LW-1:0]      t_rdata;
   logic               any_hit;
   logic [7:0]         lo_idx, hi_idx;
   logic [CW-1:0]      word_cnt;
   logic [8:0]         size_new;
   logic [8:0]         csr_clamped;
   logic               is_mod;

   assign req_ready = (state_ff == bbd_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign done_fire = (state_ff == bbd_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign is_mod    = (req_ff.kind == bbd_pkg::KIND_REMOVE) ||
                      (req_ff.kind == bbd_pkg::KIND_REDUCE) ||
                      (req_ff.kind == bbd_pkg::KIND_ADD);

   always_comb begin
      csr_clamped = csr_data;
      if (csr_data == 9'd0) begin
         csr_clamped = 9'd1;
      end else if (csr_data > DS_MAX) begin
         csr_clamped = DS_MAX;
      end
   end

   bbd_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_words (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wdata),
      .rd_en   (w_rd_en),
      .rd_addr (w_rd_addr),
      .rd_data (w_rdata)
   );

   bbd_ram #(.WIDTH(LW), .DEPTH(NLEVELS)) u_tags (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (dst_ff),
      .wr_data (p_ff),
      .rd_en   (t_rd_en),
      .rd_addr (t_rd_addr),
      .rd_data (t_rdata)
   );

   // Word datapath: one bitmap word per cycle as it returns from the RAM.
   always_comb begin
      int wi, v, a, ds;
      logic [WORD_BITS-1:0] full, qm;
      wi = int'(pw_ff);
      a  = int'(req_ff.value_index);
      ds = int'(dsize_ff);
      for (int j = 0; j < WORD_BITS; j++) begin
         v = wi * WORD_BITS + j;
         full[j]  = (v < ds);
         bmask[j] = (v == a) && (a < ds);
         case (req_ff.kind)
            bbd_pkg::KIND_NEXT: qm[j] = (v > a);
            bbd_pkg::KIND_PREV: qm[j] = (v < a);
            bbd_pkg::KIND_HAVE: qm[j] = (v == a);
            default:            qm[j] = 1'b1;
         endcase
      end
      word_d  = wvalid_ff[src_ff] ? w_rdata : full;
      hits    = word_d & qm;
      any_hit = |hits;
      lo_idx  = 8'd0;
      hi_idx  = 8'd0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (hits[j]) lo_idx = 8'(wi * WORD_BITS + j);
      end
      for (int j = 0; j < WORD_BITS; j++) begin
         if (hits[j]) hi_idx = 8'(wi * WORD_BITS + j);
      end
      word_cnt = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         word_cnt = word_cnt + CW'(word_d[j]);
      end
      case (req_ff.kind)
         bbd_pkg::KIND_REMOVE: w_wdata = word_d & ~bmask;
         bbd_pkg::KIND_ADD:    w_wdata = word_d | bmask;
         default:              w_wdata = bmask;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      tag_cur   = tvalid_ff[top_ff] ? t_rdata : '0;
      pop_more  = (top_ff != '0) && (tag_cur > p_ff);
      push      = (tag_cur < p_ff) && (int'(top_ff) < MAX_LEVEL);
      t_rd_en   = (state_ff == bbd_pkg::ST_POP_RD);
      t_rd_addr = top_ff;
      t_wr_en   = done_fire && ((req_ff.kind == bbd_pkg::KIND_REMOVE) ||
                                (req_ff.kind == bbd_pkg::KIND_REDUCE));
      w_rd_en   = (state_ff == bbd_pkg::ST_SWEEP) && (int'(rcnt_ff) < NW);
      w_rd_addr = AW'(int'(src_ff) * NW + int'(rcnt_ff));
      w_wr_en   = (state_ff == bbd_pkg::ST_SWEEP) && rd_vld_ff && is_mod;
      w_wr_addr = AW'(int'(dst_ff) * NW + int'(pw_ff));
      case (req_ff.kind)
         bbd_pkg::KIND_REMOVE:  size_new = (size_ff != 9'd0) ? size_ff - 9'd1 : 9'd0;
         bbd_pkg::KIND_REDUCE:  size_new = 9'd1;
         bbd_pkg::KIND_ADD:     size_new = (size_ff < dsize_ff) ? size_ff + 9'd1 : size_ff;
         bbd_pkg::KIND_RESTORE: size_new = (int'(cnt_ff) > int'(dsize_ff)) ?
                                           dsize_ff : 9'(cnt_ff);
         default:               size_new = size_ff;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bbd_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  bbd_pkg::KIND_REMOVE, bbd_pkg::KIND_REDUCE, bbd_pkg::KIND_RESTORE:
                     state_in = bbd_pkg::ST_POP_RD;
                  bbd_pkg::KIND_ADD, bbd_pkg::KIND_NEXT, bbd_pkg::KIND_PREV,
                  bbd_pkg::KIND_HAVE, bbd_pkg::KIND_HEAD, bbd_pkg::KIND_TAIL:
                     state_in = bbd_pkg::ST_SWEEP;
                  default:
                     state_in = bbd_pkg::ST_DONE;
               endcase
            end
         end
         bbd_pkg::ST_POP_RD:  state_in = bbd_pkg::ST_POP_CHK;
         bbd_pkg::ST_POP_CHK: state_in = pop_more ? bbd_pkg::ST_POP_RD : bbd_pkg::ST_SWEEP;
         bbd_pkg::ST_SWEEP: begin
            if (rd_vld_ff && (int'(pw_ff) == NW - 1)) state_in = bbd_pkg::ST_DONE;
         end
         bbd_pkg::ST_DONE: begin
            if (done_fire) state_in = bbd_pkg::ST_IDLE;
         end
         default: state_in = bbd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         top_ff       <= '0;
         dsize_ff     <= DS_RST;
         size_ff      <= DS_RST;
         wvalid_ff    <= '0;
         tvalid_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rcnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            req_ff    <= req_data;
            p_ff      <= (int'(req_data.search_level) > MAX_LEVEL) ?
                         LW'(MAX_LEVEL) : LW'(req_data.search_level);
            src_ff    <= top_ff;
            dst_ff    <= top_ff;
            found_ff  <= 1'b0;
            res_ff    <= 8'd0;
            cnt_ff    <= '0;
            rcnt_ff   <= '0;
            rd_vld_ff <= 1'b0;
         end
         if (state_ff == bbd_pkg::ST_POP_CHK) begin
            if (pop_more) begin
               top_ff <= top_ff - LW'(1);
            end else begin
               src_ff <= top_ff;
               if (req_ff.kind != bbd_pkg::KIND_RESTORE && push) begin
                  dst_ff <= top_ff + LW'(1);
               end else begin
                  dst_ff <= top_ff;
               end
            end
         end
         if (state_ff == bbd_pkg::ST_SWEEP) begin
            rd_vld_ff <= w_rd_en;
            pw_ff     <= rcnt_ff;
            if (w_rd_en) rcnt_ff <= rcnt_ff + WC'(1);
            if (rd_vld_ff) begin
               cnt_ff <= cnt_ff + word_cnt;
               if (any_hit) begin
                  case (req_ff.kind)
                     bbd_pkg::KIND_NEXT, bbd_pkg::KIND_HEAD: begin
                        if (!found_ff) res_ff <= lo_idx;
                        found_ff <= 1'b1;
                     end
                     bbd_pkg::KIND_PREV, bbd_pkg::KIND_TAIL: begin
                        res_ff   <= hi_idx;
                        found_ff <= 1'b1;
                     end
                     bbd_pkg::KIND_HAVE: found_ff <= 1'b1;
                     default: ;
                  endcase
               end
            end
         end
         if (done_fire) begin
            rsp_valid_ff        <= 1'b1;
            rsp_ff.found        <= found_ff;
            rsp_ff.result_index <= res_ff;
            rsp_ff.current_size <= size_new;
            size_ff             <= size_new;
            if (is_mod) wvalid_ff[dst_ff] <= 1'b1;
            if (t_wr_en) begin
               tvalid_ff[dst_ff] <= 1'b1;
               top_ff            <= dst_ff;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // Reload: every level reads as the full domain again.
         if (csr_valid) begin
            dsize_ff  <= csr_clamped;
            size_ff   <= csr_clamped;
            top_ff    <= '0;
            wvalid_ff <= '0;
            tvalid_ff <= '0;
         end
      end
   end
endmodule

### design/bbd_checker.sv
// Port-level checker of the bitset domain store, bound to the top level.
// Depends on bbd_pkg and backtrackable_bitset_domain_macros.svh.
`include "backtrackable_bitset_domain_macros.svh"
module bbd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bbd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bbd_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [8:0]       csr_data
);
   // A stalled result beat holds.
   `BBD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // Operations run one at a time, so the input closes after a beat.
   `BBD_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
   // A miss never reports an index.
   `BBD_ASSERT_NOW(a_miss_index, rsp_valid && !rsp_data.found, rsp_data.result_index == 8'd0)
   // No result is left over from before reset.
   `BBD_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid)
endmodule

bind backtrackable_bitset_domain bbd_checker u_bbd_checker (.*);

### tb/tb_backtrackable_bitset_domain.sv
// Testbench of the backtrackable bitset domain store: predicts each result
// beat from its own model of the level stack and compares every field.
// Depends on bbd_pkg and the top level backtrackable_bitset_domain.
`timescale 1ns / 100ps

module tb_backtrackable_bitset_domain;
   localparam int DOM_MAX = 256;
   localparam int NW      = 4;
   localparam int LVL_MAX = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   // Kinds past the last defined one must leave the store untouched.
   localparam logic [3:0] KIND_BAD_FIRST = 4'd9;
   localparam logic [3:0] KIND_BAD_LAST  = 4'd15;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   bbd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   bbd_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [8:0]       csr_data;

   // Predictor state.
   logic [63:0] dom_bits [0:LVL_MAX][0:NW-1];
   int unsigned lvl_tag [0:LVL_MAX];
   int unsigned top_lvl;
   int unsigned size_cnt;
   int unsigned dom_size;

   bbd_pkg::rsp_type expected_rsps [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          stall_enable;

   backtrackable_bitset_domain DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit bit_at(int unsigned l, int unsigned v);
      if (v >= dom_size) return 1'b0;
      return dom_bits[l][v / 64][v % 64];
   endfunction

   function automatic void bit_set(int unsigned l, int unsigned v, bit on);
      if (v >= dom_size) return;
      dom_bits[l][v / 64][v % 64] = on;
   endfunction

   function automatic void reload_domain(int unsigned sz);
      dom_size = sz;
      for (int l = 0; l <= LVL_MAX; l++) begin
         lvl_tag[l] = 0;
         for (int w = 0; w < NW; w++) begin
            for (int b = 0; b < 64; b++) begin
               dom_bits[l][w][b] = (w * 64 + b) < sz;
            end
         end
      end
      top_lvl = 0;
      size_cnt = sz;
   endfunction

   function automatic void pop_levels(int unsigned p);
      while (top_lvl > 0 && lvl_tag[top_lvl] > p) top_lvl--;
   endfunction

   function automatic void push_level(int unsigned p, bit copy);
      if (lvl_tag[top_lvl] < p && top_lvl < LVL_MAX) begin
         top_lvl++;
         if (copy) begin
            for (int w = 0; w < NW; w++) dom_bits[top_lvl][w] = dom_bits[top_lvl - 1][w];
         end
      end
   endfunction

   function automatic bbd_pkg::rsp_type predict_domain_op(bbd_pkg::req_type r);
      bbd_pkg::rsp_type o;
      int unsigned      a, p, cnt;
      a = r.value_index;
      p = r.search_level;
      o = '0;
      if (p > LVL_MAX) p = LVL_MAX;
      case (r.kind)
         bbd_pkg::KIND_REMOVE: begin
            pop_levels(p);
            push_level(p, 1'b1);
            bit_set(top_lvl, a, 1'b0);
            lvl_tag[top_lvl] = p;
            if (size_cnt > 0) size_cnt--;
         end
         bbd_pkg::KIND_REDUCE: begin
            pop_levels(p);
            push_level(p, 1'b0);
            for (int w = 0; w < NW; w++) dom_bits[top_lvl][w] = '0;
            bit_set(top_lvl, a, 1'b1);
            lvl_tag[top_lvl] = p;
            size_cnt = 1;
         end
         bbd_pkg::KIND_ADD: begin
            bit_set(top_lvl, a, 1'b1);
            if (size_cnt < dom_size) size_cnt++;
         end
         bbd_pkg::KIND_RESTORE: begin
            pop_levels(p);
            cnt = 0;
            for (int w = 0; w < NW; w++) cnt += $countones(dom_bits[top_lvl][w]);
            size_cnt = cnt > dom_size ? dom_size : cnt;
         end
         bbd_pkg::KIND_NEXT: begin
            for (int unsigned i = a + 1; i < dom_size; i++) begin
               if (bit_at(top_lvl, i)) begin
                  o.found = 1'b1; o.result_index = 8'(i); break;
               end
            end
         end
         bbd_pkg::KIND_PREV: begin
            for (int unsigned i = a; i > 0; i--) begin
               if (bit_at(top_lvl, i - 1)) begin
                  o.found = 1'b1; o.result_index = 8'(i - 1); break;
               end
            end
         end
         bbd_pkg::KIND_HAVE: o.found = bit_at(top_lvl, a);
         bbd_pkg::KIND_HEAD: begin
            for (int unsigned i = 0; i < dom_size; i++) begin
               if (bit_at(top_lvl, i)) begin
                  o.found = 1'b1; o.result_index = 8'(i); break;
               end
            end
         end
         bbd_pkg::KIND_TAIL: begin
            for (int unsigned i = dom_size; i > 0; i--) begin
               if (bit_at(top_lvl, i - 1)) begin
                  o.found = 1'b1; o.result_index = 8'(i - 1); break;
               end
            end
         end
         default: ;
      endcase
      o.current_size = 9'(size_cnt);
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic bit roll_idle();
      return stall_enable && ($urandom_range(99) < 15);
   endfunction

   // Result checker and receiver stalls.
   always @(posedge clock) begin
      bbd_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         idle_cycles <= 0;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected beat", int'(rsp_data), 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch("found", int'(rsp_data.found), int'(want.found));
            if (rsp_data.result_index !== want.result_index)
               report_mismatch("result_index", int'(rsp_data.result_index),
                               int'(want.result_index));
            if (rsp_data.current_size !== want.current_size)
               report_mismatch("current_size", int'(rsp_data.current_size),
                               int'(want.current_size));
         end
      end else if (!(req_valid && req_ready) && !(csr_valid && csr_ready)) begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : !roll_idle();
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Valid stays up after the beat is taken; the next call either replaces
   // the payload or drops valid on that same falling edge.
   task automatic send_op(logic [3:0] kind, int unsigned value, int unsigned level);
      bbd_pkg::req_type r;
      bbd_pkg::rsp_type predicted;
      while (roll_idle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      r.kind = kind;
      r.value_index = 8'(value);
      r.search_level = 7'(level);
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_domain_op(r);
      expected_rsps = {expected_rsps, predicted};
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_domain_size(int unsigned value);
      drain_results();
      csr_data <= 9'(value);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reload_domain(value < 1 ? 1 : (value > DOM_MAX ? DOM_MAX : value));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_extremes();
      // Full domain after reset, then every kind at the edges.
      send_op(bbd_pkg::KIND_HEAD, 0, 0);
      send_op(bbd_pkg::KIND_TAIL, 0, 0);
      send_op(bbd_pkg::KIND_REMOVE, 0, 1);
      send_op(bbd_pkg::KIND_REMOVE, 255, 2);
      send_op(bbd_pkg::KIND_NEXT, 255, 0);
      send_op(bbd_pkg::KIND_NEXT, 0, 0);
      send_op(bbd_pkg::KIND_PREV, 0, 0);
      send_op(bbd_pkg::KIND_PREV, 255, 0);
      send_op(bbd_pkg::KIND_HAVE, 255, 0);
      send_op(bbd_pkg::KIND_HAVE, 1, 0);
      send_op(bbd_pkg::KIND_REDUCE, 170, 127);
      send_op(bbd_pkg::KIND_ADD, 85, 0);
      send_op(bbd_pkg::KIND_RESTORE, 0, 1);
      send_op(bbd_pkg::KIND_RESTORE, 0, 0);
      send_op(KIND_BAD_FIRST, 255, 127);
      send_op(KIND_BAD_LAST, 0, 0);
      // Values outside a small domain and an empty domain.
      write_domain_size(1);
      send_op(bbd_pkg::KIND_REMOVE, 200, 3);
      send_op(bbd_pkg::KIND_REMOVE, 0, 4);
      send_op(bbd_pkg::KIND_HEAD, 0, 0);
      send_op(bbd_pkg::KIND_TAIL, 0, 0);
      send_op(bbd_pkg::KIND_ADD, 200, 0);
      send_op(bbd_pkg::KIND_ADD, 0, 0);
      send_op(bbd_pkg::KIND_REDUCE, 9, 5);
   endtask

   task automatic test_random_search(int unsigned count);
      int unsigned lvl, sz, k;
      lvl = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 150 == 0) begin
            k = $urandom_range(3);
            sz = k == 0 ? 256 : (k == 1 ? $urandom_range(1, 8) : $urandom_range(1, 511));
            if (n % 300 == 0) sz = (n % 600 == 0) ? 0 : 511;
            write_domain_size(sz);
            lvl = 0;
         end
         stall_enable = !(n >= 400 && n < 550);
         if (n == 700) drain_results();
         // Mostly a plausible descent and backtrack, with some noise.
         k = $urandom_range(99);
         if (k < 25) begin
            if (lvl < 70) lvl += $urandom_range(0, 2);
            send_op(bbd_pkg::KIND_REMOVE, $urandom_range(255), lvl);
         end else if (k < 32) begin
            if (lvl < 70) lvl++;
            send_op(bbd_pkg::KIND_REDUCE, $urandom_range(255), lvl);
         end else if (k < 45) begin
            lvl = lvl == 0 ? 0 : $urandom_range(lvl - 1);
            send_op(bbd_pkg::KIND_RESTORE, $urandom, lvl);
         end else if (k < 52) begin
            send_op(bbd_pkg::KIND_ADD, $urandom_range(255), $urandom_range(127));
         end else if (k < 95) begin
            send_op(4'(bbd_pkg::KIND_NEXT + $urandom_range(4)), $urandom_range(255),
                    $urandom_range(127));
         end else begin
            send_op(4'($urandom_range(15)), $urandom_range(255), $urandom_range(127));
         end
      end
   endtask

   initial begin
      stall_enable = 1'b1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      reload_domain(DOM_MAX);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_extremes();
      test_random_search(1130);
      drain_results();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+design
design/bbd_pkg.sv
design/bbd_ram.sv
design/backtrackable_bitset_domain.sv
design/bbd_checker.sv
tb/tb_backtrackable_bitset_domain.sv
